// ----- design/lkf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared types and constants for the windowed Lucas-Kanade flow solver.
// ----------------------------------------------------------------------------
package lkf_pkg;

  localparam int GX_W    = 15;
  localparam int GT_W    = 13;
  localparam int FLOW_W  = 24;
  localparam int SQ_W    = 36;
  localparam int TX_W    = 35;
  localparam int OP_W    = 37;
  localparam int MAG_W   = 36;
  localparam int PROD_W  = 74;
  localparam int DM_W    = 73;
  localparam int DVD_W   = 88;
  localparam int NPROD   = 6;
  localparam int IDX_W   = 3;
  localparam int MCNT_W  = 6;
  localparam int DCNT_W  = 7;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(MAG_W - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DVD_W - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NPROD - 1);

  localparam logic [FLOW_W-1:0] FLOW_POS_LIM = 24'h7FFFFF;
  localparam logic [FLOW_W-1:0] FLOW_NEG_LIM = 24'h800000;

  typedef struct packed {
    logic [SQ_W-1:0] xx;
    logic [SQ_W-1:0] xy;
    logic [SQ_W-1:0] yy;
    logic [TX_W-1:0] xt;
    logic [TX_W-1:0] yt;
  } sums_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_COMB,
    S_SCALE,
    S_DIV,
    S_EMIT
  } solve_state_t;

endpackage
`default_nettype wire

// ----- design/lkf_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkf_if
// Valid/ready channels: gradient words in, flow words out.
// ----------------------------------------------------------------------------
interface lkf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lkf_pkg::GX_W-1:0]     grad_x;
  logic signed [lkf_pkg::GX_W-1:0]     grad_y;
  logic signed [lkf_pkg::GT_W-1:0]     grad_t;
  logic                                window_end;

  modport source (output valid, grad_x, grad_y, grad_t, window_end, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_t, window_end, output ready);
endinterface

interface lkf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lkf_pkg::FLOW_W-1:0]   flow_x;
  logic signed [lkf_pkg::FLOW_W-1:0]   flow_y;
  logic                                singular;
  logic                                saturated;

  modport source (output valid, flow_x, flow_y, singular, saturated, input ready);
  modport sink   (input valid, flow_x, flow_y, singular, saturated, output ready);
endinterface
`default_nettype wire

// ----- design/lkf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkf_front
// Gradient products and the five window sums; pushes sums at window end.
// ----------------------------------------------------------------------------
module lkf_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [lkf_pkg::GX_W-1:0]   grad_x,
  input  wire logic signed [lkf_pkg::GX_W-1:0]   grad_y,
  input  wire logic signed [lkf_pkg::GT_W-1:0]   grad_t,
  input  wire logic                              window_end,
  input  wire logic [lkf_pkg::QCNT_W-1:0]        q_level,
  output logic                                   push,
  output lkf_pkg::sums_t                         push_data
);

  logic                      st_valid;
  logic                      st_last;
  logic signed [29:0]        pxx, pxy, pyy;
  logic signed [27:0]        pxt, pyt;
  lkf_pkg::sums_t            sums;
  lkf_pkg::sums_t            sums_next;
  logic [lkf_pkg::QCNT_W:0]  committed;
  logic                      accept;

  assign committed = {1'b0, q_level} + {{lkf_pkg::QCNT_W{1'b0}}, st_valid & st_last};
  assign in_ready  = committed < (lkf_pkg::QCNT_W+1)'(lkf_pkg::QDEPTH);
  assign accept    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      st_last  <= 1'b0;
    end else begin
      st_valid <= accept;
      st_last  <= accept & window_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pxx <= grad_x * grad_x;
      pxy <= grad_x * grad_y;
      pyy <= grad_y * grad_y;
      pxt <= grad_x * grad_t;
      pyt <= grad_y * grad_t;
    end
  end

  always_comb begin
    sums_next.xx = sums.xx + {{6{pxx[29]}}, pxx};
    sums_next.xy = sums.xy + {{6{pxy[29]}}, pxy};
    sums_next.yy = sums.yy + {{6{pyy[29]}}, pyy};
    sums_next.xt = sums.xt + {{7{pxt[27]}}, pxt};
    sums_next.yt = sums.yt + {{7{pyt[27]}}, pyt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (st_valid) begin
      sums <= st_last ? '0 : sums_next;
    end
  end

  assign push      = st_valid & st_last;
  assign push_data = sums_next;

endmodule
`default_nettype wire

// ----- design/lkf_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkf_queue
// Two-entry queue of window sums between accumulation and solve.
// ----------------------------------------------------------------------------
module lkf_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire lkf_pkg::sums_t              push_data,
  input  wire logic                        pop,
  output logic                             valid,
  output lkf_pkg::sums_t                   data,
  output logic [lkf_pkg::QCNT_W-1:0]       level
);

  lkf_pkg::sums_t               mem [lkf_pkg::QDEPTH];
  logic [lkf_pkg::QPTR_W-1:0]   wptr;
  logic [lkf_pkg::QPTR_W-1:0]   rptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      level <= level + lkf_pkg::QCNT_W'(push) - lkf_pkg::QCNT_W'(pop);
    end
  end

  assign valid = level != '0;
  assign data  = mem[rptr];

endmodule
`default_nettype wire

// ----- design/lkf_solve.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkf_solve
// Cramer's-rule solve: serial shift-add multiplier for the six products,
// restoring divider for both flow components, saturation and output register.
// ----------------------------------------------------------------------------
module lkf_solve (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire lkf_pkg::sums_t                    q_data,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [lkf_pkg::FLOW_W-1:0]      flow_x,
  output logic signed [lkf_pkg::FLOW_W-1:0]      flow_y,
  output logic                                   singular,
  output logic                                   saturated
);

  lkf_pkg::solve_state_t state, state_next;

  logic signed [lkf_pkg::OP_W-1:0]   ra, rb, rc, rd, re;
  logic signed [lkf_pkg::OP_W-1:0]   opa, opb, nega, negb;
  logic [lkf_pkg::MAG_W-1:0]         mag_a, mag_b;
  logic [lkf_pkg::IDX_W-1:0]         idx;

  logic [2*lkf_pkg::MAG_W-1:0]       mcand, acc, acc_next;
  logic [lkf_pkg::MAG_W-1:0]         mplier;
  logic                              msign;
  logic [lkf_pkg::MCNT_W-1:0]        mcnt;
  logic signed [lkf_pkg::PROD_W-1:0] sprod;
  logic signed [lkf_pkg::PROD_W-1:0] prod [lkf_pkg::NPROD];

  logic signed [lkf_pkg::PROD_W-1:0] det, nx, ny, num, det_abs, num_abs;
  logic [lkf_pkg::DM_W-1:0]          dm, nm;
  logic                              dneg;
  logic                              comp;
  logic                              fneg;
  logic [lkf_pkg::DVD_W-1:0]         scaled, dvd, quo, q_fin;
  logic [lkf_pkg::DM_W:0]            rem, rsh;
  logic                              ge;
  logic [lkf_pkg::DCNT_W-1:0]        dcnt;
  logic [lkf_pkg::FLOW_W-1:0]        lim, mag24, val24;
  logic                              over;
  logic                              mul_done, div_done;

  // operand select
  always_comb begin
    case (idx)
      3'd0:    begin opa = ra; opb = rc; end
      3'd1:    begin opa = rb; opb = rb; end
      3'd2:    begin opa = rc; opb = rd; end
      3'd3:    begin opa = rb; opb = re; end
      3'd4:    begin opa = ra; opb = re; end
      3'd5:    begin opa = rb; opb = rd; end
      default: begin opa = ra; opb = rc; end
    endcase
    nega  = -opa;
    negb  = -opb;
    mag_a = opa[lkf_pkg::OP_W-1] ? nega[lkf_pkg::MAG_W-1:0] : opa[lkf_pkg::MAG_W-1:0];
    mag_b = opb[lkf_pkg::OP_W-1] ? negb[lkf_pkg::MAG_W-1:0] : opb[lkf_pkg::MAG_W-1:0];
  end

  assign acc_next = acc + (mplier[0] ? mcand : '0);
  assign sprod    = msign ? -$signed({2'b00, acc_next}) : $signed({2'b00, acc_next});
  assign mul_done = mcnt == lkf_pkg::MUL_LAST;

  assign det     = prod[0] - prod[1];
  assign nx      = prod[2] - prod[3];
  assign ny      = prod[4] - prod[5];
  assign det_abs = det[lkf_pkg::PROD_W-1] ? -det : det;
  assign num     = comp ? ny : nx;
  assign num_abs = num[lkf_pkg::PROD_W-1] ? -num : num;
  assign nm      = num_abs[lkf_pkg::DM_W-1:0];
  // times 25600
  assign scaled  = ({15'd0, nm} << 14) + ({15'd0, nm} << 13) + ({15'd0, nm} << 10);

  assign rsh      = {rem[lkf_pkg::DM_W-1:0], dvd[lkf_pkg::DVD_W-1]};
  assign ge       = rsh >= {1'b0, dm};
  assign q_fin    = {quo[lkf_pkg::DVD_W-2:0], ge};
  assign div_done = dcnt == lkf_pkg::DIV_LAST;
  assign lim      = fneg ? lkf_pkg::FLOW_NEG_LIM : lkf_pkg::FLOW_POS_LIM;
  assign over     = q_fin > {64'd0, lim};
  assign mag24    = over ? lim : q_fin[lkf_pkg::FLOW_W-1:0];
  assign val24    = fneg ? -mag24 : mag24;

  always_ff @(posedge clk) begin
    if (rst) state <= lkf_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      lkf_pkg::S_IDLE:  if (q_valid) state_next = lkf_pkg::S_LOAD;
      lkf_pkg::S_LOAD:  state_next = lkf_pkg::S_MUL;
      lkf_pkg::S_MUL: begin
        if (mul_done) state_next = (idx == lkf_pkg::IDX_LAST) ? lkf_pkg::S_COMB : lkf_pkg::S_LOAD;
      end
      lkf_pkg::S_COMB:  state_next = (det == '0) ? lkf_pkg::S_EMIT : lkf_pkg::S_SCALE;
      lkf_pkg::S_SCALE: state_next = lkf_pkg::S_DIV;
      lkf_pkg::S_DIV: begin
        if (div_done) state_next = comp ? lkf_pkg::S_EMIT : lkf_pkg::S_SCALE;
      end
      lkf_pkg::S_EMIT:  if (out_ready) state_next = lkf_pkg::S_IDLE;
      default:          state_next = lkf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == lkf_pkg::S_IDLE) & q_valid;
    out_valid = state == lkf_pkg::S_EMIT;
  end

  always_ff @(posedge clk) begin
    case (state)
      lkf_pkg::S_IDLE: begin
        ra  <= {1'b0, q_data.xx};
        rb  <= {q_data.xy[lkf_pkg::SQ_W-1], q_data.xy};
        rc  <= {1'b0, q_data.yy};
        rd  <= {{2{q_data.xt[lkf_pkg::TX_W-1]}}, q_data.xt};
        re  <= {{2{q_data.yt[lkf_pkg::TX_W-1]}}, q_data.yt};
        idx <= '0;
      end
      lkf_pkg::S_LOAD: begin
        mcand  <= {{lkf_pkg::MAG_W{1'b0}}, mag_b};
        mplier <= mag_a;
        acc    <= '0;
        msign  <= opa[lkf_pkg::OP_W-1] ^ opb[lkf_pkg::OP_W-1];
        mcnt   <= '0;
      end
      lkf_pkg::S_MUL: begin
        acc    <= acc_next;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        mcnt   <= mcnt + 1'b1;
        if (mul_done) begin
          prod[idx] <= sprod;
          idx       <= idx + 1'b1;
        end
      end
      lkf_pkg::S_COMB: begin
        dm        <= det_abs[lkf_pkg::DM_W-1:0];
        dneg      <= det[lkf_pkg::PROD_W-1];
        comp      <= 1'b0;
        saturated <= 1'b0;
        singular  <= det == '0;
        if (det == '0) begin
          flow_x <= '0;
          flow_y <= '0;
        end
      end
      lkf_pkg::S_SCALE: begin
        dvd  <= scaled;
        rem  <= '0;
        quo  <= '0;
        dcnt <= '0;
        fneg <= num[lkf_pkg::PROD_W-1] == dneg;
      end
      lkf_pkg::S_DIV: begin
        rem  <= ge ? rsh - {1'b0, dm} : rsh;
        dvd  <= dvd << 1;
        quo  <= q_fin;
        dcnt <= dcnt + 1'b1;
        if (div_done) begin
          if (comp) flow_y <= val24;
          else      flow_x <= val24;
          saturated <= saturated | over;
          comp      <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/lk_window_flow_solve.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lk_window_flow_solve
// Windowed Lucas-Kanade flow: accumulate gradient sums, solve at window end.
// ----------------------------------------------------------------------------
// Gradient words are taken one per cycle while the sum queue has room.
// Each flow word is computed after its window_end word by the serial 36-bit
// multiplier (six products) and the 88-step divider (two components). The
// next window is accumulated while a solve runs.
// Reset (rst, synchronous): sums cleared, queue emptied, solver idle.
// ----------------------------------------------------------------------------
module lk_window_flow_solve (
  input  wire logic  clk,
  input  wire logic  rst,
  lkf_in_if.sink     pix,
  lkf_out_if.source  flow
);

  logic                          q_push;
  lkf_pkg::sums_t                q_push_data;
  logic                          q_pop;
  logic                          q_valid;
  lkf_pkg::sums_t                q_data;
  logic [lkf_pkg::QCNT_W-1:0]    q_level;

  lkf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pix.valid),
    .in_ready   (pix.ready),
    .grad_x     (pix.grad_x),
    .grad_y     (pix.grad_y),
    .grad_t     (pix.grad_t),
    .window_end (pix.window_end),
    .q_level    (q_level),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  lkf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data),
    .level     (q_level)
  );

  lkf_solve u_solve (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (flow.valid),
    .out_ready (flow.ready),
    .flow_x    (flow.flow_x),
    .flow_y    (flow.flow_y),
    .singular  (flow.singular),
    .saturated (flow.saturated)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level < lkf_pkg::QCNT_W'(lkf_pkg::QDEPTH)))
    else $error("sum queue overflow");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty sum queue");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (flow.valid && flow.singular) |->
      (flow.flow_x == '0 && flow.flow_y == '0 && !flow.saturated))
    else $error("singular word with nonzero flow");

endmodule
`default_nettype wire
